FILE: rtl/core/grs_pkg.sv
// shared constants and types of the gradient relief shader
package grs_pkg;

    // input gradient width and packed stream widths
    localparam int GW       = 32;
    localparam int IN_DW    = ((2 * GW + 7) / 8) * 8;
    localparam int OUT_DW   = 24;
    localparam int CW       = 24;

    // prescaled magnitude bits and derived arithmetic widths
    localparam int PL       = 30;
    localparam int SW       = 6;
    localparam int DDW      = 15;
    localparam int QW       = 2 * PL + 2;
    localparam int RW       = QW / 2;
    localparam int TW       = PL + 3;
    localparam int KW       = 16;
    localparam int NW       = TW + KW;
    localparam int DQ       = 20;
    localparam int WW       = 18;
    localparam int BNW      = WW + 8;
    localparam int BSW      = WW + 1;
    localparam int BQ       = 8;

    // fixed point constants
    localparam logic [DDW-1:0] GRAD_DIV = DDW'(25600);
    localparam logic [KW-1:0]  K1_Q16   = KW'(62772);
    localparam logic [KW-1:0]  K2_Q16   = KW'(28602);
    localparam logic [WW-1:0]  ONE_Q16  = WW'(65536);

    // configuration register indexes
    localparam int CFG_IW = 1;
    localparam logic [CFG_IW-1:0] REG_DARK  = 1'b0;
    localparam logic [CFG_IW-1:0] REG_LIGHT = 1'b1;
    localparam logic [CW-1:0] DARK_RST  = CW'(24'h004000);
    localparam logic [CW-1:0] LIGHT_RST = CW'(24'h40FF20);

    // result buffer
    localparam int FD  = 128;
    localparam int FAW = 7;
    localparam int FCW = FAW + 1;

    // values carried alongside the square root pipeline
    typedef struct packed {
        logic [NW-1:0] n1;
        logic [NW-1:0] n2;
        logic          neg1;
        logic          neg2;
    } t_carry;

endpackage

FILE: rtl/core/gradient_relief_shader.sv
// top level of the gradient relief shader pipeline
//
// channel   | direction | handshake           | payload
// s_axis    | in        | tvalid/tready       | tdata: x_gradient, y_gradient
// m_axis    | out       | tvalid/tready       | tdata: red, green, blue
// cfg       | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one pixel per clock while s_axis_tready is high; from input transaction to output
// valid a pixel passes prescale, squares, a 31-stage square root, a 20-stage divider for the
// light factors and an 8-stage divider per channel, each divider behind an
// entry register, then the result buffer and its output register.
// the pipeline never stalls: a 128-entry result buffer absorbs back pressure
// and s_axis_tready drops only when 128 transactions are outstanding.
// synchronous active-low reset clears valid bits and counters and loads the configuration defaults.
module gradient_relief_shader (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [31:0] x_gradient, [63:32] y_gradient
    input  logic [grs_pkg::IN_DW-1:0]  s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [grs_pkg::OUT_DW-1:0] m_axis_tdata,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [grs_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [grs_pkg::CW-1:0]     i_cfg_data
);
    import grs_pkg::*;

    logic [CW-1:0] r_dark, r_light;
    logic          in_acc, out_acc;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dark  <= DARK_RST;
            r_light <= LIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_DARK:  r_dark  <= i_cfg_data;
                REG_LIGHT: r_light <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // stage a: input register
    logic                 r_a_v;
    logic signed [GW-1:0] r_a_x, r_a_y;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else          r_a_v <= in_acc;
        r_a_x <= s_axis_tdata[GW-1:0];
        r_a_y <= s_axis_tdata[2*GW-1:GW];
    end

    // stage b: magnitudes and prescale shift
    logic [GW-1:0]  ax, ay, axy, axs, ays;
    logic [SW-1:0]  sh;
    logic [DDW-1:0] dsh;
    always_comb begin
        ax  = r_a_x[GW-1] ? GW'(-r_a_x) : GW'(r_a_x);
        ay  = r_a_y[GW-1] ? GW'(-r_a_y) : GW'(r_a_y);
        axy = ax | ay;
        sh  = '0;
        for (int i = PL; i < GW; i++) begin
            if (axy[i]) sh = SW'(i - PL + 1);
        end
        axs = ax >> sh;
        ays = ay >> sh;
        dsh = GRAD_DIV >> sh;
    end

    logic           r_b_v, r_b_xn, r_b_yn;
    logic [PL-1:0]  r_b_xm, r_b_ym;
    logic [DDW-1:0] r_b_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_v <= 1'b0;
        else          r_b_v <= r_a_v;
        r_b_xm <= axs[PL-1:0];
        r_b_ym <= ays[PL-1:0];
        r_b_xn <= r_a_x[GW-1];
        r_b_yn <= r_a_y[GW-1];
        r_b_d  <= dsh;
    end

    // stage c: squares, first numerator, second factor term
    logic signed [TW-1:0] xs, ys, hs, tsum;
    always_comb begin
        xs   = r_b_xn ? -TW'(r_b_xm) : TW'(r_b_xm);
        ys   = r_b_yn ? -TW'(r_b_ym) : TW'(r_b_ym);
        hs   = TW'(r_b_d >> 1);
        tsum = (ys <<< 1) - xs - hs;
    end

    logic                 r_c_v, r_c_neg1;
    logic [2*PL-1:0]      r_c_x2, r_c_y2;
    logic [2*DDW-1:0]     r_c_d2;
    logic [NW-1:0]        r_c_n1;
    logic signed [TW-1:0] r_c_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_v <= 1'b0;
        else          r_c_v <= r_b_v;
        r_c_x2   <= r_b_xm * r_b_xm;
        r_c_y2   <= r_b_ym * r_b_ym;
        r_c_d2   <= r_b_d * r_b_d;
        r_c_n1   <= NW'(r_b_ym) * NW'(K1_Q16);
        r_c_neg1 <= !r_b_yn;
        r_c_t    <= tsum;
    end

    // stage d: radicand and second numerator
    logic [TW-1:0] tabs;
    assign tabs = r_c_t[TW-1] ? TW'(-r_c_t) : TW'(r_c_t);

    logic          r_sv [0:RW];
    logic [QW-1:0] r_srem [0:RW];
    logic [RW-1:0] r_sroot [0:RW];
    t_carry        r_scar [0:RW];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else          r_sv[0] <= r_c_v;
        r_srem[0]       <= QW'(r_c_x2) + QW'(r_c_y2) + QW'(r_c_d2);
        r_sroot[0]      <= '0;
        r_scar[0].n1    <= r_c_n1;
        r_scar[0].n2    <= NW'(tabs) * NW'(K2_Q16);
        r_scar[0].neg1  <= r_c_neg1;
        r_scar[0].neg2  <= r_c_t[TW-1];
    end

    // square root: one result bit per stage, most significant first
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [QW-1:0] trial;
        logic          take;
        always_comb begin
            trial = (QW'(r_sroot[k]) << (B + 1)) | (QW'(1) << (2 * B));
            take  = r_srem[k] >= trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[k+1] <= 1'b0;
            else          r_sv[k+1] <= r_sv[k];
            r_srem[k+1]  <= take ? r_srem[k] - trial : r_srem[k];
            r_sroot[k+1] <= take ? (r_sroot[k] | (RW'(1) << B)) : r_sroot[k];
            r_scar[k+1]  <= r_scar[k];
        end
    end

    // factor division: entry register, then one quotient bit per stage
    logic          r_dv [0:DQ];
    logic [RW-1:0] r_drt [0:DQ];
    logic [RW-1:0] r_drem1 [0:DQ];
    logic [RW-1:0] r_drem2 [0:DQ];
    logic [DQ-1:0] r_dnum1 [0:DQ];
    logic [DQ-1:0] r_dnum2 [0:DQ];
    logic [DQ-1:0] r_dq1 [0:DQ];
    logic [DQ-1:0] r_dq2 [0:DQ];
    logic          r_dneg1 [0:DQ];
    logic          r_dneg2 [0:DQ];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv[0] <= 1'b0;
        else          r_dv[0] <= r_sv[RW];
        r_drt[0]   <= r_sroot[RW];
        r_drem1[0] <= RW'(r_scar[RW].n1 >> DQ);
        r_drem2[0] <= RW'(r_scar[RW].n2 >> DQ);
        r_dnum1[0] <= r_scar[RW].n1[DQ-1:0];
        r_dnum2[0] <= r_scar[RW].n2[DQ-1:0];
        r_dq1[0]   <= '0;
        r_dq2[0]   <= '0;
        r_dneg1[0] <= r_scar[RW].neg1;
        r_dneg2[0] <= r_scar[RW].neg2;
    end

    for (genvar j = 0; j < DQ; j++) begin : g_div
        logic [RW:0] p1, p2;
        logic        t1, t2;
        always_comb begin
            p1 = {r_drem1[j], r_dnum1[j][DQ-1]};
            p2 = {r_drem2[j], r_dnum2[j][DQ-1]};
            t1 = p1 >= {1'b0, r_drt[j]};
            t2 = p2 >= {1'b0, r_drt[j]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[j+1] <= 1'b0;
            else          r_dv[j+1] <= r_dv[j];
            r_drt[j+1]   <= r_drt[j];
            r_drem1[j+1] <= t1 ? RW'(p1 - {1'b0, r_drt[j]}) : RW'(p1);
            r_drem2[j+1] <= t2 ? RW'(p2 - {1'b0, r_drt[j]}) : RW'(p2);
            r_dnum1[j+1] <= r_dnum1[j] << 1;
            r_dnum2[j+1] <= r_dnum2[j] << 1;
            r_dq1[j+1]   <= {r_dq1[j][DQ-2:0], t1};
            r_dq2[j+1]   <= {r_dq2[j][DQ-2:0], t2};
            r_dneg1[j+1] <= r_dneg1[j];
            r_dneg2[j+1] <= r_dneg2[j];
        end
    end

    // weights: clamp the factors and offset by one
    logic          rzero;
    logic [DQ-1:0] qc1, qc2;
    assign rzero = r_drt[DQ] == '0;
    assign qc1   = rzero ? '0 : (r_dq1[DQ] > DQ'(ONE_Q16) ? DQ'(ONE_Q16) : r_dq1[DQ]);
    assign qc2   = rzero ? '0 : (r_dq2[DQ] > DQ'(ONE_Q16) ? DQ'(ONE_Q16) : r_dq2[DQ]);

    logic          r_w_v;
    logic [WW-1:0] r_w1, r_w2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_w_v <= 1'b0;
        else          r_w_v <= r_dv[DQ];
        r_w1 <= r_dneg1[DQ] ? ONE_Q16 - WW'(qc1) : ONE_Q16 + WW'(qc1);
        r_w2 <= r_dneg2[DQ] ? ONE_Q16 - WW'(qc2) : ONE_Q16 + WW'(qc2);
    end

    // blend products per channel, then numerator and weight sum
    logic           r_m_v, r_n_v;
    logic [BNW-1:0] r_m_pd [0:2];
    logic [BNW-1:0] r_m_pl [0:2];
    logic [BSW-1:0] r_m_sum, r_n_sum;
    logic [BNW-1:0] r_n_num [0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_n_v <= 1'b0;
        end else begin
            r_m_v <= r_w_v;
            r_n_v <= r_m_v;
        end
        for (int c = 0; c < 3; c++) begin
            r_m_pd[c]  <= BNW'(r_dark[16-8*c +: 8]) * BNW'(r_w1);
            r_m_pl[c]  <= BNW'(r_light[16-8*c +: 8]) * BNW'(r_w2);
            r_n_num[c] <= r_m_pd[c] + r_m_pl[c];
        end
        r_m_sum <= BSW'(r_w1) + BSW'(r_w2);
        r_n_sum <= r_m_sum;
    end

    // blend division: entry register, then one quotient bit per stage
    logic           r_bv [0:BQ];
    logic [BSW-1:0] r_bs [0:BQ];
    logic [BSW-1:0] r_brem [0:BQ][0:2];
    logic [BQ-1:0]  r_bnum [0:BQ][0:2];
    logic [BQ-1:0]  r_bq [0:BQ][0:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv[0] <= 1'b0;
        else          r_bv[0] <= r_n_v;
        r_bs[0] <= r_n_sum;
        for (int c = 0; c < 3; c++) begin
            r_brem[0][c] <= BSW'(r_n_num[c] >> BQ);
            r_bnum[0][c] <= r_n_num[c][BQ-1:0];
            r_bq[0][c]   <= '0;
        end
    end

    for (genvar j = 0; j < BQ; j++) begin : g_bdiv
        for (genvar c = 0; c < 3; c++) begin : g_ch
            logic [BSW:0] p;
            logic         t;
            always_comb begin
                p = {r_brem[j][c], r_bnum[j][c][BQ-1]};
                t = p >= {1'b0, r_bs[j]};
            end
            always_ff @(posedge i_clk) begin
                r_brem[j+1][c] <= t ? BSW'(p - {1'b0, r_bs[j]}) : BSW'(p);
                r_bnum[j+1][c] <= r_bnum[j][c] << 1;
                r_bq[j+1][c]   <= {r_bq[j][c][BQ-2:0], t};
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_bv[j+1] <= 1'b0;
            else          r_bv[j+1] <= r_bv[j];
            r_bs[j+1] <= r_bs[j];
        end
    end

    // result pixel, zero when the weight sum vanishes
    logic [OUT_DW-1:0] res;
    assign res = (r_bs[BQ] == '0) ? '0 : {r_bq[BQ][2], r_bq[BQ][1], r_bq[BQ][0]};

    // result buffer and output register
    logic [OUT_DW-1:0] r_mem [0:FD-1];
    logic [FAW-1:0]    r_wr, r_rd;
    logic [FCW-1:0]    r_fcnt, r_cred;
    logic              r_out_v, push, pop;
    logic [OUT_DW-1:0] r_out_d;

    assign push    = r_bv[BQ];
    assign pop     = (r_fcnt != '0) && (!r_out_v || m_axis_tready);
    assign out_acc = r_out_v && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= res;
        if (pop)  r_out_d <= r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_fcnt  <= '0;
            r_cred  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (push) r_wr <= r_wr + FAW'(1);
            if (pop)  r_rd <= r_rd + FAW'(1);
            r_fcnt  <= r_fcnt + FCW'(push) - FCW'(pop);
            r_cred  <= r_cred + FCW'(in_acc) - FCW'(out_acc);
            r_out_v <= pop ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_v);
        end
    end

    assign s_axis_tready = r_cred < FCW'(FD);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_d;

endmodule
